>>> rtl/core/grid_local_minimum_detector_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the grid local minimum detector
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRID_LOCAL_MINIMUM_DETECTOR_UNIT_ASSERT_SVH
`define GRID_LOCAL_MINIMUM_DETECTOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define GLMD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define GLMD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/glmd_pkg.sv
// ----------------------------------------------------------------------------
// glmd_pkg
// Shared types and constants of the grid local minimum detector.
// ----------------------------------------------------------------------------
package glmd_pkg;

	// Configuration port geometry and register indexes
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;
	localparam int FRAME_COLS_W = 9;
	localparam int FRAME_ROWS_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'b1;

	localparam logic [FRAME_COLS_W-1:0] FRAME_COLS_RESET = 9'd100;
	localparam logic [FRAME_ROWS_W-1:0] FRAME_ROWS_RESET = 16'd100;

	// Number of decisions one item can cause
	localparam int SLOTS = 3;

	typedef struct packed {
		logic [7:0] height;
	} cell_item_t;

	typedef struct packed {
		logic [7:0]  cell_col;
		logic [15:0] cell_row;
		logic [7:0]  cell_height;
		logic        is_minimum;
		logic [23:0] minima_so_far;
		logic        last_of_run;
		logic        frame_done;
	} decision_t;

	// One line buffer entry: the two earlier rows at one column
	typedef struct packed {
		logic [7:0] two_back;
		logic [7:0] one_back;
	} lb_word_t;

	// Decisions caused by one item, with a mask of the slots in use
	typedef struct packed {
		logic [SLOTS-1:0]             pend;
		decision_t [SLOTS-1:0]        slot;
	} bundle_t;

endpackage

>>> rtl/core/glmd_stream_if.sv
// ----------------------------------------------------------------------------
// glmd_stream_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface glmd_stream_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/glmd_line_buf.sv
// ----------------------------------------------------------------------------
// glmd_line_buf
// Line buffer memory: one write port, two registered read ports, with
// write-to-read forwarding when a read hits the entry being written.
// ----------------------------------------------------------------------------
module glmd_line_buf
	import glmd_pkg::*;
#(
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  lb_word_t                 wr_word,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output lb_word_t                 rd_word_a,
	output lb_word_t                 rd_word_b
);

	lb_word_t mem [DEPTH];
	lb_word_t rd_a_q;
	lb_word_t rd_b_q;
	lb_word_t byp_q;
	logic     hit_a_q;
	logic     hit_b_q;

	// Write and read the array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
		byp_q  <= wr_word;
	end

	// Note reads that collide with the write of the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_a_q <= 1'b0;
			hit_b_q <= 1'b0;
		end else begin
			hit_a_q <= wr_en && (wr_addr == rd_addr_a);
			hit_b_q <= wr_en && (wr_addr == rd_addr_b);
		end
	end

	// Forward the fresh word over the stale array data
	assign rd_word_a = hit_a_q ? byp_q : rd_a_q;
	assign rd_word_b = hit_b_q ? byp_q : rd_b_q;

endmodule

>>> rtl/core/glmd_out_queue.sv
// ----------------------------------------------------------------------------
// glmd_out_queue
// Holds the decisions of one item and hands them out one per handshake
// through an output register, marking the final one of the item.
// ----------------------------------------------------------------------------
`include "grid_local_minimum_detector_unit_assert.svh"

module glmd_out_queue
	import glmd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  bundle_t       bundle,
	output logic          can_take,
	glmd_stream_if.source decisions
);

	logic [SLOTS-1:0] pend_s1;
	decision_t [SLOTS-1:0] slot_s1;
	decision_t        out_q;
	decision_t        out_next;
	logic             out_valid_q;
	logic             out_free;
	logic             move;
	logic [SLOTS-1:0] rest;
	logic [1:0]       sel;

	// Pick the oldest pending slot
	always_comb begin
		if (pend_s1[0]) begin
			sel = 2'd0;
		end else if (pend_s1[1]) begin
			sel = 2'd1;
		end else begin
			sel = 2'd2;
		end
	end

	assign rest     = pend_s1 & (pend_s1 - SLOTS'(1));
	assign out_free = !out_valid_q || decisions.ready;
	assign move     = (pend_s1 != '0) && out_free;
	assign can_take = (pend_s1 == '0) || (move && (rest == '0));

	// Hold the item's decisions, drop each one as it moves out
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= '0;
		end else if (push) begin
			pend_s1 <= bundle.pend;
		end else if (move) begin
			pend_s1 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_s1 <= bundle.slot;
		end
	end

	// Mark the final decision of the item
	always_comb begin
		out_next             = slot_s1[sel];
		out_next.last_of_run = (rest == '0);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move) begin
			out_valid_q <= 1'b1;
		end else if (decisions.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q <= out_next;
		end
	end

	assign decisions.valid = out_valid_q;
	assign decisions.data  = out_q;

	`GLMD_ASSERT_SAME(a_push_when_free, push, can_take, "item pushed while queue busy")
	`GLMD_ASSERT_NEXT(a_push_nonempty, push, pend_s1 != '0, "empty item pushed")
	`GLMD_ASSERT_SAME(a_done_ends_run, out_valid_q && out_q.frame_done, out_q.last_of_run,
		"frame end decision not last of its item")

endmodule

>>> rtl/core/grid_local_minimum_detector_unit.sv
// ----------------------------------------------------------------------------
// grid_local_minimum_detector_unit
// Streams a raster of 8-bit heights in row-major order and decides for each
// cell whether all existing left, right, upper and lower neighbours are
// strictly higher. Decisions of a row come out while the next row streams
// in; the last row is decided as it arrives. Each decision carries the
// running count of minima, which clears after the frame's final cell. An
// item is taken every cycle while it causes at most one decision and the
// consumer keeps up; on the last row an item past the first column causes
// two decisions (three at the row end), and the input then waits while the
// single output register hands them out one per handshake. The two earlier
// rows live in one line buffer memory with two registered read ports, read
// ahead at the current and the next column, with forwarding from the write
// of the same cycle. Frame size writes take effect at once and keep the
// position, so a column or row at or past the new size ends the row or
// makes it the last; write them only while no item is in flight. The line
// buffer needs no clearing after reset.
// ----------------------------------------------------------------------------
`include "grid_local_minimum_detector_unit_assert.svh"

module grid_local_minimum_detector_unit
	import glmd_pkg::*;
#(
	parameter int MAX_COLS = 256
) (
	input  logic                  clk,
	input  logic                  arst_n,
	glmd_stream_if.sink           cells,
	glmd_stream_if.source         decisions,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int CW   = $clog2(MAX_COLS);
	localparam int CNTW = (CW + 1 > FRAME_COLS_W) ? CW + 1 : FRAME_COLS_W;

	logic [FRAME_COLS_W-1:0] cols_q;
	logic [FRAME_ROWS_W-1:0] rows_q;
	logic [CW-1:0]           col_q;
	logic [15:0]             row_q;
	logic [23:0]             cnt_q;
	lb_word_t                left1_q;
	logic [7:0]              prev2_q;

	logic [CNTW-1:0]         cols_ext;
	logic [CNTW-1:0]         cols_eff;
	logic [FRAME_ROWS_W-1:0] rows_eff;
	logic                    row_end;
	logic                    last_row;
	logic                    has_left;
	logic                    has_left2;
	logic                    row_ge1;
	logic                    row_ge2;
	logic                    accept;
	logic                    can_take;
	logic [CW-1:0]           col_next;
	lb_word_t                entry_a;
	lb_word_t                entry_b;
	lb_word_t                wr_word;
	logic [7:0]              h;
	logic                    m0, m1, m2;
	logic [SLOTS-1:0]        pend;
	logic [23:0]             cnt0, cnt1, cnt2;
	bundle_t                 bundle;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q <= FRAME_COLS_RESET;
			rows_q <= FRAME_ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FRAME_COLS: cols_q <= cfg_wdata[FRAME_COLS_W-1:0];
				REG_FRAME_ROWS: rows_q <= cfg_wdata[FRAME_ROWS_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective frame size: zero acts as one, columns clamp to the buffer
	always_comb begin
		cols_ext = CNTW'(cols_q);
		if (cols_ext == '0) begin
			cols_eff = CNTW'(1);
		end else if (cols_ext > CNTW'(MAX_COLS)) begin
			cols_eff = CNTW'(MAX_COLS);
		end else begin
			cols_eff = cols_ext;
		end
		rows_eff = (rows_q == '0) ? FRAME_ROWS_W'(1) : rows_q;
	end

	assign h         = cells.data.height;
	assign accept    = cells.valid && can_take;
	assign cells.ready = can_take;

	assign row_end   = (CNTW'(col_q) + CNTW'(1)) >= cols_eff;
	assign last_row  = (17'(row_q) + 17'd1) >= 17'(rows_eff);
	assign has_left  = col_q != '0;
	assign has_left2 = col_q > CW'(1);
	assign row_ge1   = row_q != '0;
	assign row_ge2   = row_q > 16'd1;

	// Read the current and next column ahead of their use
	assign col_next = !accept ? col_q : (row_end ? '0 : col_q + CW'(1));
	assign wr_word  = '{two_back: entry_a.one_back, one_back: h};

	glmd_line_buf #(
		.DEPTH (MAX_COLS)
	) u_line_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (accept),
		.wr_addr   (col_q),
		.wr_word   (wr_word),
		.rd_addr_a (col_next),
		.rd_addr_b (col_next + CW'(1)),
		.rd_word_a (entry_a),
		.rd_word_b (entry_b)
	);

	// Decide the cell above, the cell to the left on the last row and the
	// row-end cell on the last row
	always_comb begin
		m0 = (!has_left || (left1_q.two_back > entry_a.one_back))
		  && (row_end   || (entry_b.one_back > entry_a.one_back))
		  && (!row_ge2  || (entry_a.two_back > entry_a.one_back))
		  && (h > entry_a.one_back);
		m1 = (!has_left2 || (prev2_q > left1_q.one_back))
		  && (h > left1_q.one_back)
		  && (!row_ge1   || (left1_q.two_back > left1_q.one_back));
		m2 = (!has_left  || (left1_q.one_back > h))
		  && (!row_ge1   || (entry_a.one_back > h));

		pend = {last_row && row_end, last_row && has_left, row_ge1};
		cnt0 = cnt_q + 24'(pend[0] && m0);
		cnt1 = cnt0 + 24'(pend[1] && m1);
		cnt2 = cnt1 + 24'(pend[2] && m2);

		bundle.pend = pend;

		bundle.slot[0].cell_col      = 8'(col_q);
		bundle.slot[0].cell_row      = row_q - 16'd1;
		bundle.slot[0].cell_height   = entry_a.one_back;
		bundle.slot[0].is_minimum    = m0;
		bundle.slot[0].minima_so_far = cnt0;
		bundle.slot[0].last_of_run   = 1'b0;
		bundle.slot[0].frame_done    = 1'b0;

		bundle.slot[1].cell_col      = 8'(col_q - CW'(1));
		bundle.slot[1].cell_row      = row_q;
		bundle.slot[1].cell_height   = left1_q.one_back;
		bundle.slot[1].is_minimum    = m1;
		bundle.slot[1].minima_so_far = cnt1;
		bundle.slot[1].last_of_run   = 1'b0;
		bundle.slot[1].frame_done    = 1'b0;

		bundle.slot[2].cell_col      = 8'(col_q);
		bundle.slot[2].cell_row      = row_q;
		bundle.slot[2].cell_height   = h;
		bundle.slot[2].is_minimum    = m2;
		bundle.slot[2].minima_so_far = cnt2;
		bundle.slot[2].last_of_run   = 1'b0;
		bundle.slot[2].frame_done    = 1'b1;
	end

	// Advance position and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			cnt_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= last_row ? 16'd0 : row_q + 16'd1;
				cnt_q <= last_row ? 24'd0 : cnt2;
			end else begin
				col_q <= col_q + CW'(1);
				cnt_q <= cnt2;
			end
		end
	end

	// Keep the last two written columns for left neighbours
	always_ff @(posedge clk) begin
		if (accept) begin
			left1_q <= wr_word;
			prev2_q <= left1_q.one_back;
		end
	end

	glmd_out_queue u_out_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept && (pend != '0)),
		.bundle    (bundle),
		.can_take  (can_take),
		.decisions (decisions)
	);

	`GLMD_ASSERT_NEXT(a_count_clears, accept && row_end && last_row, cnt_q == 24'd0,
		"minima count not cleared at frame end")
	`GLMD_ASSERT_SAME(a_first_row_silent, accept && (row_q == 16'd0) && !last_row,
		pend == '0, "decision produced on first row")
	`GLMD_ASSERT_SAME(a_last_row_pairs, accept && last_row && has_left && row_ge1,
		$countones(pend) >= 2, "last row item lost a decision")

endmodule
